>>> design/lpcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Looped PCM channel mixer package
// Shared constants, command and status types for the mixer front, queue and
// back end.
// ----------------------------------------------------------------------------
package lpcm_pkg;

    localparam int NUM_CHANNELS     = 4;
    localparam int SAMPLE_ADDR_BITS = 16;
    localparam int FRAC_BITS        = 12;
    localparam int MIX_SHIFT        = 8;

    localparam int CH_BITS   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MASK_W    = 4;

    localparam int ACT_W     = 3;
    localparam int MADDR_W   = 16;
    localparam int SAMPLE_W  = 8;
    localparam int CHAN_W    = 2;
    localparam int START_W   = 16;
    localparam int INC_W     = 16;
    localparam int VOL_W     = 7;
    localparam int POS_W     = 32;

    localparam int ACT_LSB   = 0;
    localparam int MADDR_LSB = ACT_LSB + ACT_W;
    localparam int SMP_LSB   = MADDR_LSB + MADDR_W;
    localparam int CHAN_LSB  = SMP_LSB + SAMPLE_W;
    localparam int START_LSB = CHAN_LSB + CHAN_W;
    localparam int INC_LSB   = START_LSB + START_W;
    localparam int VOL_LSB   = INC_LSB + INC_W;
    localparam int END_LSB   = VOL_LSB + VOL_W;
    localparam int LOOP_LSB  = END_LSB + POS_W;
    localparam int IN_BITS   = LOOP_LSB + POS_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = SAMPLE_W + MASK_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int PROD_W    = SAMPLE_W + VOL_W + 1;
    localparam int SUM_W     = PROD_W + CH_BITS;
    localparam int SHIFTED_W = SUM_W - MIX_SHIFT;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int DIV_W     = POS_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 3'd0,
        ACT_START = 3'd1,
        ACT_VOL   = 3'd2,
        ACT_INC   = 3'd3,
        ACT_STOP  = 3'd4,
        ACT_MIX   = 3'd5
    } action_t;

    typedef struct packed {
        action_t                    action;
        logic [MADDR_W-1:0]         mem_address;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [CHAN_W-1:0]          channel;
        logic [START_W-1:0]         start_address;
        logic [INC_W-1:0]           increment;
        logic [VOL_W-1:0]           volume;
        logic [POS_W-1:0]           end_position;
        logic [POS_W-1:0]           loop_span;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic busy;
        logic div_busy;
        logic out_load;
    } back_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ADDR,
        BK_MUL,
        BK_ACC,
        BK_DIV,
        BK_WRAP,
        BK_OUT
    } back_state_t;

endpackage
`default_nettype wire

>>> design/lpcm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer command front end
// Accepts input transactions, decodes the action, drops unknown actions and
// hands decoded commands to the command queue.
// ----------------------------------------------------------------------------
module lpcm_front
    import lpcm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  wire fifo_stat_t            fifo_stat,
    output logic                       fe_push,
    output cmd_t                       fe_cmd
);

    logic              valid_reg;
    logic              valid_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic              accept;
    logic              known;
    logic [ACT_W-1:0]  act_raw;

    assign act_raw       = s_axis_tdata[ACT_LSB +: ACT_W];
    assign fe_push       = valid_reg && !fifo_stat.full;
    assign s_axis_tready = !valid_reg || !fifo_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fe_cmd        = cmd_reg;

    always_comb begin
        unique case (act_raw)
            ACT_WRITE, ACT_START, ACT_VOL, ACT_INC, ACT_STOP, ACT_MIX: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    always_comb begin
        cmd_next.action        = action_t'(act_raw);
        cmd_next.mem_address   = s_axis_tdata[MADDR_LSB +: MADDR_W];
        cmd_next.sample_value  = s_axis_tdata[SMP_LSB +: SAMPLE_W];
        cmd_next.channel       = s_axis_tdata[CHAN_LSB +: CHAN_W];
        cmd_next.start_address = s_axis_tdata[START_LSB +: START_W];
        cmd_next.increment     = s_axis_tdata[INC_LSB +: INC_W];
        cmd_next.volume        = s_axis_tdata[VOL_LSB +: VOL_W];
        cmd_next.end_position  = s_axis_tdata[END_LSB +: POS_W];
        cmd_next.loop_span     = s_axis_tdata[LOOP_LSB +: POS_W];
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = known;
        end else if (fe_push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

>>> design/lpcm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer command queue
// A short first-in first-out queue of decoded commands between the front end
// and the back end.
// ----------------------------------------------------------------------------
module lpcm_fifo
    import lpcm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output fifo_stat_t stat
);

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

>>> design/lpcm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Loop remainder unit
// Restoring divider that produces the remainder of an unsigned division,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpcm_div
    import lpcm_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     rem_next;
    logic [DIV_W-1:0]     dvd_reg;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        if (trial >= {1'b0, dsr_reg}) begin
            rem_next = diff[DIV_W-1:0];
        end else begin
            rem_next = trial[DIV_W-1:0];
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= '0;
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
        end
    end

endmodule
`default_nettype wire

>>> design/lpcm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer back end
// Executes queued commands: sample memory writes, channel control and the
// channel-by-channel mix sequence with position advance and loop handling.
// ----------------------------------------------------------------------------
module lpcm_back
    import lpcm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cmd_t                   head,
    input  wire fifo_stat_t             fifo_stat,
    output logic                        pop,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output back_stat_t                  stat
);

    localparam logic [CH_BITS-1:0] CH_LAST = CH_BITS'(NUM_CHANNELS - 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [SAMPLE_W-1:0] mem_reg [2**SAMPLE_ADDR_BITS];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_ADDR_BITS-1:0] rd_addr;
    logic                        rd_en;
    logic                        wr_en;

    logic [NUM_CHANNELS-1:0] active_reg;
    logic [START_W-1:0]      base_reg [NUM_CHANNELS];
    logic [POS_W-1:0]        pos_reg  [NUM_CHANNELS];
    logic [INC_W-1:0]        step_reg [NUM_CHANNELS];
    logic [VOL_W-1:0]        vol_reg  [NUM_CHANNELS];
    logic [POS_W-1:0]        end_reg  [NUM_CHANNELS];
    logic [POS_W-1:0]        loop_reg [NUM_CHANNELS];

    logic [CH_BITS-1:0]       idx_reg;
    logic [POS_W-1:0]         pos_tmp_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [SUM_W-1:0]  sum_reg;

    logic                        m_valid_reg;
    logic signed [SAMPLE_W-1:0]  m_sample_reg;
    logic [MASK_W-1:0]           m_mask_reg;
    logic signed [SAMPLE_W-1:0]  sat_sample;
    logic signed [SHIFTED_W-1:0] shifted;
    logic [MASK_W-1:0]           mask_now;

    logic [CH_BITS-1:0] cmd_ch;
    logic               ch_ok;
    logic               end_hit;
    logic               no_loop;
    logic               div_start;
    logic               advance;
    logic               last_ch;
    logic               out_load;
    logic               stop_here;

    div_req_t div_req;
    div_rsp_t div_rsp;

    lpcm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cmd_ch  = head.channel[CH_BITS-1:0];
    assign ch_ok   = (int'(head.channel) < NUM_CHANNELS);
    assign last_ch = (idx_reg == CH_LAST);
    assign end_hit = (pos_tmp_reg >= end_reg[idx_reg]);
    assign no_loop = (loop_reg[idx_reg] == '0);
    assign rd_addr = base_reg[idx_reg][SAMPLE_ADDR_BITS-1:0]
                   + pos_reg[idx_reg][FRAC_BITS +: SAMPLE_ADDR_BITS];
    assign prod_next = PROD_W'(rd_data_reg) * PROD_W'($signed({1'b0, vol_reg[idx_reg]}));

    assign div_req.start    = div_start;
    assign div_req.dividend = pos_tmp_reg - end_reg[idx_reg];
    assign div_req.divisor  = loop_reg[idx_reg];

    assign shifted = sum_reg[SUM_W-1:MIX_SHIFT];

    always_comb begin
        if (&shifted[SHIFTED_W-1:SAMPLE_W-1] || ~|shifted[SHIFTED_W-1:SAMPLE_W-1]) begin
            sat_sample = shifted[SAMPLE_W-1:0];
        end else if (shifted[SHIFTED_W-1]) begin
            sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_comb begin
        mask_now = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (c < MASK_W) begin
                mask_now[c] = active_reg[c];
            end
        end
    end

    always_comb begin
        pop       = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        advance   = 1'b0;
        stop_here = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                pop   = !fifo_stat.empty;
                wr_en = pop && (head.action == ACT_WRITE);
            end
            BK_ADDR: begin
                rd_en   = active_reg[idx_reg];
                advance = !active_reg[idx_reg];
            end
            BK_MUL: begin
            end
            BK_ACC: begin
                div_start = end_hit && !no_loop;
                stop_here = end_hit && no_loop;
                advance   = !div_start;
            end
            BK_DIV: begin
            end
            BK_WRAP: begin
                advance = 1'b1;
            end
            BK_OUT: begin
                out_load = !m_valid_reg || m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (pop && head.action == ACT_MIX) begin
                    state_next = BK_ADDR;
                end
            end
            BK_ADDR: begin
                if (active_reg[idx_reg]) begin
                    state_next = BK_MUL;
                end else if (last_ch) begin
                    state_next = BK_OUT;
                end
            end
            BK_MUL: begin
                state_next = BK_ACC;
            end
            BK_ACC: begin
                if (div_start) begin
                    state_next = BK_DIV;
                end else begin
                    state_next = last_ch ? BK_OUT : BK_ADDR;
                end
            end
            BK_DIV: begin
                if (div_rsp.done) begin
                    state_next = BK_WRAP;
                end
            end
            BK_WRAP: begin
                state_next = last_ch ? BK_OUT : BK_ADDR;
            end
            BK_OUT: begin
                if (out_load) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            active_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop && ch_ok && head.action == ACT_START) begin
                active_reg[cmd_ch] <= 1'b1;
            end
            if (pop && ch_ok && head.action == ACT_STOP) begin
                active_reg[cmd_ch] <= 1'b0;
            end
            if (stop_here) begin
                active_reg[idx_reg] <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && ch_ok) begin
            unique case (head.action)
                ACT_START: begin
                    base_reg[cmd_ch] <= head.start_address;
                    step_reg[cmd_ch] <= head.increment;
                    vol_reg[cmd_ch]  <= head.volume;
                    end_reg[cmd_ch]  <= head.end_position;
                    loop_reg[cmd_ch] <= head.loop_span;
                    pos_reg[cmd_ch]  <= '0;
                end
                ACT_VOL: begin
                    vol_reg[cmd_ch] <= head.volume;
                end
                ACT_INC: begin
                    step_reg[cmd_ch] <= head.increment;
                end
                default: begin
                end
            endcase
        end
        if (pop && head.action == ACT_MIX) begin
            idx_reg <= '0;
            sum_reg <= '0;
        end
        if (state_reg == BK_MUL) begin
            prod_reg    <= prod_next;
            pos_tmp_reg <= pos_reg[idx_reg] + POS_W'(step_reg[idx_reg]);
        end
        if (state_reg == BK_ACC) begin
            sum_reg          <= sum_reg + SUM_W'(prod_reg);
            pos_reg[idx_reg] <= pos_tmp_reg;
        end
        if (state_reg == BK_DIV && div_rsp.done) begin
            pos_tmp_reg <= end_reg[idx_reg] + div_rsp.remainder;
        end
        if (state_reg == BK_WRAP) begin
            pos_reg[idx_reg] <= pos_tmp_reg - loop_reg[idx_reg];
        end
        if (advance && !last_ch) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (out_load) begin
            m_sample_reg <= sat_sample;
            m_mask_reg   <= mask_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[head.mem_address[SAMPLE_ADDR_BITS-1:0]] <= head.sample_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({m_mask_reg, m_sample_reg});

    assign stat.busy     = (state_reg != BK_IDLE);
    assign stat.div_busy = div_rsp.busy;
    assign stat.out_load = out_load;

endmodule
`default_nettype wire

>>> design/looped_pcm_channel_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Looped PCM channel mixer
// Four-channel sample mixer with a byte sample memory, looping playback
// channels and a decoupled command front end and execution back end.
// ----------------------------------------------------------------------------
//  Channel   Direction  Width  Contents
//  s_axis    in         136    one command per transaction
//  m_axis    out        16     one mixed sample per mix command
//
// Commands pass the front-end register and the queue; the back end runs a
// non-mix command as it pops it. A mix steps through address, multiply and
// accumulate states per active channel, the address state per idle one and
// divide and wrap states per wrapping channel; the divide is bit-serial.
// Reset clears all channel activity. Either side may stall; the queue and
// output register let commands keep arriving while a result waits.
// ----------------------------------------------------------------------------
module looped_pcm_channel_mixer
    import lpcm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // action, mem_address, sample_value, channel, start_address, increment,
    // volume, end_position, loop_span
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // mixed_sample, active_mask
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic       fe_push;
    cmd_t       fe_cmd;
    cmd_t       fifo_head;
    fifo_stat_t fifo_stat;
    logic       bk_pop;
    back_stat_t bk_stat;

    lpcm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .fifo_stat     (fifo_stat),
        .fe_push       (fe_push),
        .fe_cmd        (fe_cmd)
    );

    lpcm_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fe_push),
        .push_cmd (fe_cmd),
        .pop      (bk_pop),
        .head     (fifo_head),
        .stat     (fifo_stat)
    );

    lpcm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (fifo_head),
        .fifo_stat     (fifo_stat),
        .pop           (bk_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .stat          (bk_stat)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        fe_push |-> !fifo_stat.full)
        else $error("Command pushed into a full queue.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fe_push && !bk_pop |=> !fifo_stat.empty)
        else $error("Queue lost a pushed command.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(bk_stat.out_load))
        else $error("Output became valid without a finished mix.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.div_busy |-> bk_stat.busy)
        else $error("Remainder unit running while the back end is idle.");

endmodule
`default_nettype wire

>>> verif/looped_pcm_channel_mixer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Looped PCM channel mixer testbench
// Drives command transactions into the mixer and checks every mixed sample.
// A tracker class keeps its own copy of the sample memory and the channel
// state, predicts each mix and compares it field by field with the output.
// A short directed sequence covers saturation, address and position wrap,
// loop pull-back and channel ends. Random commands with random stalls on
// both sides follow.
// ----------------------------------------------------------------------------
module looped_pcm_channel_mixer_test;
    import lpcm_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TOTAL_ITEMS  = 450;
    localparam int SETTLE_WAIT  = 200;

    localparam action_t ACT_RESERVED_LO = action_t'(3'd6);
    localparam action_t ACT_RESERVED_HI = action_t'(3'd7);

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [MASK_W-1:0]          mask;
    } mix_result_t;

    class mix_tracker;
        logic [SAMPLE_W-1:0] sample_mem [0:(1 << SAMPLE_ADDR_BITS) - 1];
        bit                  sample_known [0:(1 << SAMPLE_ADDR_BITS) - 1];
        bit                  playing [NUM_CHANNELS];
        logic [START_W-1:0]  base_addr [NUM_CHANNELS];
        logic [POS_W-1:0]    position [NUM_CHANNELS];
        logic [INC_W-1:0]    step [NUM_CHANNELS];
        logic [VOL_W-1:0]    gain [NUM_CHANNELS];
        logic [POS_W-1:0]    end_pos [NUM_CHANNELS];
        logic [POS_W-1:0]    loop_len [NUM_CHANNELS];
        mix_result_t         pending_mixes [$];
        int                  failures;
        int                  commands;
        int                  mixes_checked;
        int                  loop_wraps;
        int                  channel_ends;

        function new();
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                playing[ch]   = 1'b0;
                base_addr[ch] = '0;
                position[ch]  = '0;
                step[ch]      = '0;
                gain[ch]      = '0;
                end_pos[ch]   = '0;
                loop_len[ch]  = '0;
            end
            failures      = 0;
            commands      = 0;
            mixes_checked = 0;
            loop_wraps    = 0;
            channel_ends  = 0;
        endfunction

        function void unwritten_reads(output logic [MADDR_W-1:0] holes [$]);
            logic [MADDR_W-1:0] addr;
            holes = {};
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                addr = base_addr[ch] + MADDR_W'(position[ch] >> FRAC_BITS);
                if (playing[ch] && !sample_known[addr]) begin
                    holes.push_back(addr);
                end
            end
        endfunction

        function mix_result_t mix_channels();
            mix_result_t        r;
            int                 acc;
            int                 scaled;
            byte                smp;
            logic [MADDR_W-1:0] addr;
            acc = 0;
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                if (playing[ch]) begin
                    addr = base_addr[ch] + MADDR_W'(position[ch] >> FRAC_BITS);
                    smp = sample_mem[addr];
                    acc += smp * int'(gain[ch]);
                    position[ch] = position[ch] + POS_W'(step[ch]);
                    if (position[ch] >= end_pos[ch]) begin
                        if (loop_len[ch] == '0) begin
                            playing[ch] = 1'b0;
                            channel_ends++;
                        end else begin
                            position[ch] = end_pos[ch]
                                + ((position[ch] - end_pos[ch]) % loop_len[ch])
                                - loop_len[ch];
                            loop_wraps++;
                        end
                    end
                end
            end
            scaled = acc >>> MIX_SHIFT;
            if (scaled > 127) begin
                scaled = 127;
            end else if (scaled < -128) begin
                scaled = -128;
            end
            r.sample = SAMPLE_W'(scaled);
            r.mask = '0;
            for (int ch = 0; ch < NUM_CHANNELS && ch < MASK_W; ch++) begin
                r.mask[ch] = playing[ch];
            end
            return r;
        endfunction

        function void note_command(cmd_t c);
            commands++;
            case (c.action)
                ACT_WRITE: begin
                    sample_mem[c.mem_address]   = c.sample_value;
                    sample_known[c.mem_address] = 1'b1;
                end
                ACT_START: begin
                    base_addr[c.channel] = c.start_address;
                    step[c.channel]      = c.increment;
                    gain[c.channel]      = c.volume;
                    end_pos[c.channel]   = c.end_position;
                    loop_len[c.channel]  = c.loop_span;
                    position[c.channel]  = '0;
                    playing[c.channel]   = 1'b1;
                end
                ACT_VOL:  gain[c.channel] = c.volume;
                ACT_INC:  step[c.channel] = c.increment;
                ACT_STOP: playing[c.channel] = 1'b0;
                ACT_MIX:  pending_mixes.push_back(mix_channels());
                default: ;
            endcase
        endfunction

        function void check_mix(logic [OUT_TDATA_W-1:0] data);
            mix_result_t                exp_mix;
            logic signed [SAMPLE_W-1:0] got_sample;
            logic [MASK_W-1:0]          got_mask;
            got_sample = data[0 +: SAMPLE_W];
            got_mask   = data[SAMPLE_W +: MASK_W];
            if (pending_mixes.size() == 0) begin
                $error("unexpected mixed sample transaction: mixed_sample %0d, active_mask %h",
                       got_sample, got_mask);
                failures++;
                return;
            end
            exp_mix = pending_mixes.pop_front();
            mixes_checked++;
            if (got_sample !== exp_mix.sample) begin
                $error("mixed_sample: expected %0d, actual %0d", exp_mix.sample, got_sample);
                failures++;
            end
            if (got_mask !== exp_mix.mask) begin
                $error("active_mask: expected %h, actual %h", exp_mix.mask, got_mask);
                failures++;
            end
        endfunction
    endclass

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    bit         calm = 1'b0;
    int         cycles = 0;
    mix_tracker tracker;

    looped_pcm_channel_mixer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("looped_pcm_channel_mixer_test: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            tracker.check_mix(m_axis_tdata);
        end
        m_axis_tready <= calm || ($urandom_range(99) >= 32);
    end

    function automatic logic [IN_TDATA_W-1:0] pack_command(cmd_t c);
        logic [IN_TDATA_W-1:0] w;
        w = '0;
        w[ACT_LSB   +: ACT_W]    = c.action;
        w[MADDR_LSB +: MADDR_W]  = c.mem_address;
        w[SMP_LSB   +: SAMPLE_W] = c.sample_value;
        w[CHAN_LSB  +: CHAN_W]   = c.channel;
        w[START_LSB +: START_W]  = c.start_address;
        w[INC_LSB   +: INC_W]    = c.increment;
        w[VOL_LSB   +: VOL_W]    = c.volume;
        w[END_LSB   +: POS_W]    = c.end_position;
        w[LOOP_LSB  +: POS_W]    = c.loop_span;
        return w;
    endfunction

    // Fields that the action does not use carry random noise.
    function automatic cmd_t command_of(action_t act);
        cmd_t c;
        c.action        = act;
        c.mem_address   = MADDR_W'($urandom());
        c.sample_value  = SAMPLE_W'($urandom());
        c.channel       = CHAN_W'($urandom());
        c.start_address = START_W'($urandom());
        c.increment     = INC_W'($urandom());
        c.volume        = VOL_W'($urandom());
        c.end_position  = $urandom();
        c.loop_span     = $urandom();
        return c;
    endfunction

    function automatic logic [INC_W-1:0] pick_increment();
        case ($urandom_range(19))
            0:             return '0;
            1, 2, 3, 4, 5: return INC_W'($urandom());
            default:       return INC_W'($urandom_range(16'h1800, 1));
        endcase
    endfunction

    function automatic logic [VOL_W-1:0] pick_volume();
        if ($urandom_range(99) < 85) begin
            return VOL_W'($urandom_range(64));
        end
        return VOL_W'($urandom_range(127, 65));
    endfunction

    function automatic logic [POS_W-1:0] pick_end();
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return $urandom();
            default: return $urandom_range(32'h0004_0000, 1);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_loop(logic [POS_W-1:0] endp);
        case ($urandom_range(9))
            0, 1, 2: return '0;
            3:       return $urandom();
            4:       return $urandom_range(32'h0000_4000, 1);
            default: return (endp == '0) ? 32'd1 : $urandom_range(endp, 1);
        endcase
    endfunction

    task automatic send_command(input cmd_t c);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 32) begin
                gap++;
            end
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tdata  <= pack_command(c);
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        tracker.note_command(c);
    endtask

    task automatic write_byte(input logic [MADDR_W-1:0] addr,
                              input logic [SAMPLE_W-1:0] value);
        cmd_t c;
        c = command_of(ACT_WRITE);
        c.mem_address  = addr;
        c.sample_value = value;
        send_command(c);
    endtask

    task automatic start_channel(input logic [CHAN_W-1:0] ch, input logic [START_W-1:0] base,
                                 input logic [INC_W-1:0] inc, input logic [VOL_W-1:0] vol,
                                 input logic [POS_W-1:0] endp, input logic [POS_W-1:0] loop);
        cmd_t c;
        c = command_of(ACT_START);
        c.channel       = ch;
        c.start_address = base;
        c.increment     = inc;
        c.volume        = vol;
        c.end_position  = endp;
        c.loop_span     = loop;
        send_command(c);
    endtask

    task automatic channel_command(input action_t act, input logic [CHAN_W-1:0] ch,
                                   input logic [INC_W-1:0] inc, input logic [VOL_W-1:0] vol);
        cmd_t c;
        c = command_of(act);
        c.channel   = ch;
        c.increment = inc;
        c.volume    = vol;
        send_command(c);
    endtask

    // Bytes that the next mix would read are written first if still unknown.
    task automatic mix_once();
        logic [MADDR_W-1:0] holes [$];
        tracker.unwritten_reads(holes);
        foreach (holes[i]) begin
            write_byte(holes[i], SAMPLE_W'($urandom()));
        end
        send_command(command_of(ACT_MIX));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_mixes.size() != 0);
    endtask

    initial begin
        int               pick;
        logic [POS_W-1:0] endp;
        tracker = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        mix_once();
        write_byte(16'h0000, 8'h7F);
        write_byte(16'hFFFF, 8'h80);
        start_channel(2'd0, 16'h0000, 16'h1000, 7'd64, 32'h0000_2000, 32'd0);
        mix_once();
        mix_once();
        channel_command(ACT_VOL, 2'd0, 16'h0000, 7'd0);
        channel_command(ACT_INC, 2'd0, 16'hFFFF, 7'd0);
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            start_channel(CHAN_W'(ch), 16'h0000, 16'h0000, 7'd127, 32'hFFFF_FFFF, 32'd0);
        end
        mix_once();
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            start_channel(CHAN_W'(ch), 16'hFFFF, 16'h0000, 7'd127, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF);
        end
        mix_once();
        start_channel(2'd0, 16'h0000, 16'h0010, 7'd64, 32'd0, 32'd1);
        start_channel(2'd1, 16'hFFFF, 16'h1800, 7'd64, 32'h0000_2000, 32'h0000_1000);
        mix_once();
        mix_once();
        channel_command(ACT_STOP, 2'd2, 16'h0000, 7'd0);
        send_command(command_of(ACT_RESERVED_LO));
        send_command(command_of(ACT_RESERVED_HI));
        mix_once();

        wait_for_results();

        while (tracker.commands < TOTAL_ITEMS) begin
            calm <= (tracker.commands >= 150) && (tracker.commands < 260);
            pick = $urandom_range(99);
            if (pick < 12) begin
                write_byte($urandom_range(1) ? MADDR_W'($urandom()) : MADDR_W'($urandom_range(1023)),
                           SAMPLE_W'($urandom()));
            end else if (pick < 27) begin
                endp = pick_end();
                start_channel(CHAN_W'($urandom()),
                              $urandom_range(1) ? START_W'($urandom())
                                                : START_W'($urandom_range(255)),
                              pick_increment(), pick_volume(), endp, pick_loop(endp));
            end else if (pick < 35) begin
                channel_command(ACT_VOL, CHAN_W'($urandom()), INC_W'($urandom()), pick_volume());
            end else if (pick < 43) begin
                channel_command(ACT_INC, CHAN_W'($urandom()), pick_increment(),
                                VOL_W'($urandom()));
            end else if (pick < 48) begin
                channel_command(ACT_STOP, CHAN_W'($urandom()), INC_W'($urandom()),
                                VOL_W'($urandom()));
            end else if (pick < 95) begin
                mix_once();
            end else begin
                send_command(command_of($urandom_range(1) ? ACT_RESERVED_HI : ACT_RESERVED_LO));
            end
        end

        wait_for_results();
        repeat (SETTLE_WAIT) @(posedge aclk);

        $display("Sent %0d commands and checked %0d mixed samples, with %0d loop pull-backs",
                 tracker.commands, tracker.mixes_checked, tracker.loop_wraps);
        $display("and %0d channel ends, under random stalls on both channels.",
                 tracker.channel_ends);
        if (tracker.failures == 0 && tracker.pending_mixes.size() == 0) begin
            $display("looped_pcm_channel_mixer_test: clean");
        end else begin
            $display("looped_pcm_channel_mixer_test: errors");
        end
        $finish;
    end

endmodule
